// ===== rtl/dirty_rect_region_merge_unit_macros.svh =====
// Assertion macros shared by the checker of the dirty rectangle merge unit.
// No dependencies; included by files that hold concurrent assertions.
`ifndef DIRTY_RECT_REGION_MERGE_UNIT_MACROS_SVH
`define DIRTY_RECT_REGION_MERGE_UNIT_MACROS_SVH

// General property checked on every clock edge outside reset.
`define DRRM_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("dirty rect merge: assertion failed");

// A stalled transaction keeps valid high and its payload unchanged.
`define DRRM_ASSERT_HOLD(lbl, clk, rst_n, vld, rdy, sig) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) \
        ((vld) && !(rdy) |=> (vld) && $stable(sig))) \
        else $error("dirty rect merge: stalled transaction changed");

`endif

// ===== rtl/drrm_pkg.sv =====
// Shared types and codes for the dirty rectangle merge unit.
// No dependencies; imported by the controller, datapath and top level.
`default_nettype none

package drrm_pkg;

    localparam int IDX_IN_W = 4;
    localparam int MODE_W   = 2;

    typedef enum logic [MODE_W-1:0] {
        MODE_ADD   = 2'd0,
        MODE_CLEAR = 2'd1,
        MODE_READ  = 2'd2,
        MODE_NOP   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        RD_K,
        RD_IDX,
        RD_J1
    } rd_sel_t;

    typedef enum logic [1:0] {
        RES_NONE,
        RES_CUR,
        RES_MEM
    } res_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_READ_WAIT,
        ST_SCAN,
        ST_CHECK,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_APPEND,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic     load_item;
        logic     clear_count;
        logic     k_clear;
        logic     k_inc;
        logic     rd_en;
        rd_sel_t  rd_sel;
        logic     merge;
        logic     shift_wr;
        logic     remove;
        logic     append;
        logic     set_overflow;
        logic     out_load;
        res_sel_t res_sel;
    } drrm_cmd_t;

    typedef struct packed {
        mode_t mode;
        logic  rect_empty;
        logic  idx_hit;
        logic  k_end;
        logic  overlap;
        logic  shift_end;
        logic  full;
        logic  out_free;
    } drrm_stat_t;

endpackage

`default_nettype wire

// ===== rtl/drrm_ctrl.sv =====
// Controller state machine of the dirty rectangle merge unit.
// Depends on drrm_pkg; drives the datapath through drrm_cmd_t commands.
`default_nettype none

module drrm_ctrl
    import drrm_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire drrm_stat_t stat,
    output drrm_cmd_t       cmd
);

    state_t   state_reg, state_next;
    res_sel_t res_sel_reg, res_sel_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            res_sel_reg <= RES_NONE;
        end
        else
        begin
            state_reg   <= state_next;
            res_sel_reg <= res_sel_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        res_sel_next = res_sel_reg;
        cmd          = '0;
        cmd.rd_sel   = RD_K;
        cmd.res_sel  = res_sel_reg;
        in_ready     = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                res_sel_next = RES_NONE;
                state_next   = ST_FINISH;
                unique case (stat.mode)
                    MODE_ADD:
                    begin
                        if (!stat.rect_empty)
                        begin
                            cmd.k_clear = 1'b1;
                            state_next  = ST_SCAN;
                        end
                    end
                    MODE_CLEAR:
                    begin
                        cmd.clear_count = 1'b1;
                    end
                    MODE_READ:
                    begin
                        if (stat.idx_hit)
                        begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = RD_IDX;
                            state_next = ST_READ_WAIT;
                        end
                    end
                    MODE_NOP:
                    begin
                        state_next = ST_FINISH;
                    end
                endcase
            end
            ST_READ_WAIT:
            begin
                res_sel_next = RES_MEM;
                state_next   = ST_FINISH;
            end
            ST_SCAN:
            begin
                if (stat.k_end)
                begin
                    state_next = ST_APPEND;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_K;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (stat.overlap)
                begin
                    cmd.merge  = 1'b1;
                    state_next = ST_SHIFT_RD;
                end
                else
                begin
                    cmd.k_inc  = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SHIFT_RD:
            begin
                if (stat.shift_end)
                begin
                    cmd.remove = 1'b1;
                    state_next = ST_SCAN;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_J1;
                    state_next = ST_SHIFT_WR;
                end
            end
            ST_SHIFT_WR:
            begin
                cmd.shift_wr = 1'b1;
                state_next   = ST_SHIFT_RD;
            end
            ST_APPEND:
            begin
                if (stat.full)
                begin
                    cmd.set_overflow = 1'b1;
                    res_sel_next     = RES_NONE;
                end
                else
                begin
                    cmd.append   = 1'b1;
                    res_sel_next = RES_CUR;
                end
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/drrm_dpath.sv =====
// Datapath of the dirty rectangle merge unit: rectangle table memory, pending
// rectangle, counters and output register. Depends on drrm_pkg.
`default_nettype none

module drrm_dpath
    import drrm_pkg::*;
#(
    parameter int MAX_RECTS  = 16,
    parameter int COORD_BITS = 16,
    localparam int CNT_W     = $clog2(MAX_RECTS + 1),
    localparam int IDX_W     = $clog2(MAX_RECTS)
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic [MODE_W-1:0]            mode,
    input  wire logic signed [COORD_BITS-1:0] left_x,
    input  wire logic signed [COORD_BITS-1:0] top_y,
    input  wire logic signed [COORD_BITS-1:0] right_x,
    input  wire logic signed [COORD_BITS-1:0] bottom_y,
    input  wire logic [IDX_IN_W-1:0]          entry_index,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic signed [COORD_BITS-1:0]      out_left_x,
    output logic signed [COORD_BITS-1:0]      out_top_y,
    output logic signed [COORD_BITS-1:0]      out_right_x,
    output logic signed [COORD_BITS-1:0]      out_bottom_y,
    output logic [CNT_W-1:0]                  rect_count,
    output logic                              rect_valid,
    output logic                              overflow_flag,
    input  wire drrm_cmd_t                    cmd,
    output drrm_stat_t                        stat
);

    localparam int CW    = COORD_BITS;
    localparam int CMP_W = (CNT_W > IDX_IN_W) ? CNT_W : IDX_IN_W;

    logic [4*CW-1:0] mem [MAX_RECTS];
    logic [4*CW-1:0] rd_data_reg;
    logic [IDX_W-1:0] rd_addr;

    mode_t                mode_reg;
    logic [IDX_IN_W-1:0]  idx_reg;
    logic signed [CW-1:0] cur_lx_reg, cur_ty_reg, cur_rx_reg, cur_by_reg;
    logic signed [CW-1:0] cur_lx_next, cur_ty_next, cur_rx_next, cur_by_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CNT_W-1:0]     k_reg, k_next;
    logic [CNT_W-1:0]     j_reg, j_next;
    logic [CNT_W-1:0]     j_plus;
    logic                 ovf_reg, ovf_next;

    logic                 out_valid_reg, out_valid_next;
    logic signed [CW-1:0] out_lx_reg, out_ty_reg, out_rx_reg, out_by_reg;
    logic [CNT_W-1:0]     out_count_reg;
    logic                 out_rv_reg, out_ovf_reg;

    logic signed [CW-1:0] e_lx, e_ty, e_rx, e_by;
    logic signed [CW-1:0] res_lx, res_ty, res_rx, res_by;
    logic                 res_valid;
    logic [CMP_W-1:0]     idx_ext, count_ext;

    assign e_lx = signed'(rd_data_reg[CW-1:0]);
    assign e_ty = signed'(rd_data_reg[2*CW-1:CW]);
    assign e_rx = signed'(rd_data_reg[3*CW-1:2*CW]);
    assign e_by = signed'(rd_data_reg[4*CW-1:3*CW]);

    assign j_plus    = j_reg + CNT_W'(1);
    assign idx_ext   = CMP_W'(idx_reg);
    assign count_ext = CMP_W'(count_reg);

    always_comb
    begin
        unique case (cmd.rd_sel)
            RD_K:    rd_addr = k_reg[IDX_W-1:0];
            RD_IDX:  rd_addr = idx_ext[IDX_W-1:0];
            RD_J1:   rd_addr = j_plus[IDX_W-1:0];
            default: rd_addr = k_reg[IDX_W-1:0];
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.shift_wr)
        begin
            mem[j_reg[IDX_W-1:0]] <= rd_data_reg;
        end
        else if (cmd.append)
        begin
            mem[count_reg[IDX_W-1:0]] <= {cur_by_reg, cur_rx_reg, cur_ty_reg, cur_lx_reg};
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        cur_lx_next = cur_lx_reg;
        cur_ty_next = cur_ty_reg;
        cur_rx_next = cur_rx_reg;
        cur_by_next = cur_by_reg;
        if (cmd.load_item)
        begin
            cur_lx_next = left_x;
            cur_ty_next = top_y;
            cur_rx_next = right_x;
            cur_by_next = bottom_y;
        end
        else if (cmd.merge)
        begin
            cur_lx_next = (e_lx < cur_lx_reg) ? e_lx : cur_lx_reg;
            cur_ty_next = (e_ty < cur_ty_reg) ? e_ty : cur_ty_reg;
            cur_rx_next = (e_rx > cur_rx_reg) ? e_rx : cur_rx_reg;
            cur_by_next = (e_by > cur_by_reg) ? e_by : cur_by_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_lx_reg <= cur_lx_next;
        cur_ty_reg <= cur_ty_next;
        cur_rx_reg <= cur_rx_next;
        cur_by_reg <= cur_by_next;
        if (cmd.load_item)
        begin
            mode_reg <= mode_t'(mode);
            idx_reg  <= entry_index;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        k_next     = k_reg;
        j_next     = j_reg;
        ovf_next   = ovf_reg | cmd.set_overflow;
        priority if (cmd.clear_count)
        begin
            count_next = '0;
        end
        else if (cmd.remove)
        begin
            count_next = count_reg - CNT_W'(1);
        end
        else if (cmd.append)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        if (cmd.k_clear || cmd.remove)
        begin
            k_next = '0;
        end
        else if (cmd.k_inc)
        begin
            k_next = k_reg + CNT_W'(1);
        end
        if (cmd.merge)
        begin
            j_next = k_reg;
        end
        else if (cmd.shift_wr)
        begin
            j_next = j_plus;
        end
    end

    always_comb
    begin
        unique case (cmd.res_sel)
            RES_CUR:
            begin
                res_lx    = cur_lx_reg;
                res_ty    = cur_ty_reg;
                res_rx    = cur_rx_reg;
                res_by    = cur_by_reg;
                res_valid = 1'b1;
            end
            RES_MEM:
            begin
                res_lx    = e_lx;
                res_ty    = e_ty;
                res_rx    = e_rx;
                res_by    = e_by;
                res_valid = 1'b1;
            end
            default:
            begin
                res_lx    = '0;
                res_ty    = '0;
                res_rx    = '0;
                res_by    = '0;
                res_valid = 1'b0;
            end
        endcase
    end

    assign out_valid_next = cmd.out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            k_reg         <= '0;
            j_reg         <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            out_lx_reg    <= '0;
            out_ty_reg    <= '0;
            out_rx_reg    <= '0;
            out_by_reg    <= '0;
            out_count_reg <= '0;
            out_rv_reg    <= 1'b0;
            out_ovf_reg   <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            k_reg         <= k_next;
            j_reg         <= j_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
            if (cmd.out_load)
            begin
                out_lx_reg    <= res_lx;
                out_ty_reg    <= res_ty;
                out_rx_reg    <= res_rx;
                out_by_reg    <= res_by;
                out_count_reg <= count_reg;
                out_rv_reg    <= res_valid;
                out_ovf_reg   <= ovf_reg;
            end
        end
    end

    assign stat.mode       = mode_reg;
    assign stat.rect_empty = !((cur_rx_reg > cur_lx_reg) && (cur_by_reg > cur_ty_reg));
    assign stat.idx_hit    = idx_ext < count_ext;
    assign stat.k_end      = k_reg == count_reg;
    assign stat.overlap    = (e_rx > cur_lx_reg) && (e_lx < cur_rx_reg) &&
                             (e_by > cur_ty_reg) && (e_ty < cur_by_reg);
    assign stat.shift_end  = j_plus >= count_reg;
    assign stat.full       = count_reg == CNT_W'(MAX_RECTS);
    assign stat.out_free   = !out_valid_reg || out_ready;

    assign out_valid     = out_valid_reg;
    assign out_left_x    = out_lx_reg;
    assign out_top_y     = out_ty_reg;
    assign out_right_x   = out_rx_reg;
    assign out_bottom_y  = out_by_reg;
    assign rect_count    = out_count_reg;
    assign rect_valid    = out_rv_reg;
    assign overflow_flag = out_ovf_reg;

endmodule

`default_nettype wire

// ===== rtl/dirty_rect_region_merge_unit.sv =====
// Dirty rectangle merge unit. One transaction is taken at a time. A clear, an empty rectangle,
// the unused mode or a read past the last entry goes from dispatch straight to finish, and a
// read that hits first waits for the table read. An add scans the table one entry at a time;
// every overlap merges that entry into the pending rectangle and moves the entries after it
// down, and the scan then starts again from the first entry. All table traffic goes through the
// single read and single write port of the rectangle memory. A finished result waits in an
// output register while the next transaction is accepted. If that result has still not been
// taken when the next one finishes, the unit holds until the receiver takes it.
// Depends on drrm_pkg, drrm_ctrl and drrm_dpath.
`default_nettype none

module dirty_rect_region_merge_unit
    import drrm_pkg::*;
#(
    parameter int MAX_RECTS  = 16,
    parameter int COORD_BITS = 16,
    localparam int CNT_W     = $clog2(MAX_RECTS + 1)
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [MODE_W-1:0]            mode,
    input  wire logic signed [COORD_BITS-1:0] left_x,
    input  wire logic signed [COORD_BITS-1:0] top_y,
    input  wire logic signed [COORD_BITS-1:0] right_x,
    input  wire logic signed [COORD_BITS-1:0] bottom_y,
    input  wire logic [IDX_IN_W-1:0]          entry_index,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic signed [COORD_BITS-1:0]      out_left_x,
    output logic signed [COORD_BITS-1:0]      out_top_y,
    output logic signed [COORD_BITS-1:0]      out_right_x,
    output logic signed [COORD_BITS-1:0]      out_bottom_y,
    output logic [CNT_W-1:0]                  rect_count,
    output logic                              rect_valid,
    output logic                              overflow_flag
);

    drrm_cmd_t  cmd;
    drrm_stat_t stat;

    drrm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    drrm_dpath #(
        .MAX_RECTS  (MAX_RECTS),
        .COORD_BITS (COORD_BITS)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .mode          (mode),
        .left_x        (left_x),
        .top_y         (top_y),
        .right_x       (right_x),
        .bottom_y      (bottom_y),
        .entry_index   (entry_index),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_left_x    (out_left_x),
        .out_top_y     (out_top_y),
        .out_right_x   (out_right_x),
        .out_bottom_y  (out_bottom_y),
        .rect_count    (rect_count),
        .rect_valid    (rect_valid),
        .overflow_flag (overflow_flag),
        .cmd           (cmd),
        .stat          (stat)
    );

endmodule

`default_nettype wire

// ===== rtl/drrm_checker.sv =====
// Port-level checker for the dirty rectangle merge unit, bound to the top level.
// Depends on dirty_rect_region_merge_unit_macros.svh and the top level's ports.
`default_nettype none
`include "dirty_rect_region_merge_unit_macros.svh"

module drrm_checker #(
    parameter int MAX_RECTS  = 16,
    parameter int COORD_BITS = 16,
    localparam int CNT_W     = $clog2(MAX_RECTS + 1)
)
(
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         in_valid,
    input wire logic                         in_ready,
    input wire logic [1:0]                   mode,
    input wire logic signed [COORD_BITS-1:0] left_x,
    input wire logic signed [COORD_BITS-1:0] top_y,
    input wire logic signed [COORD_BITS-1:0] right_x,
    input wire logic signed [COORD_BITS-1:0] bottom_y,
    input wire logic [3:0]                   entry_index,
    input wire logic                         out_valid,
    input wire logic                         out_ready,
    input wire logic signed [COORD_BITS-1:0] out_left_x,
    input wire logic signed [COORD_BITS-1:0] out_top_y,
    input wire logic signed [COORD_BITS-1:0] out_right_x,
    input wire logic signed [COORD_BITS-1:0] out_bottom_y,
    input wire logic [CNT_W-1:0]             rect_count,
    input wire logic                         rect_valid,
    input wire logic                         overflow_flag
);

    `DRRM_ASSERT_HOLD(a_out_hold, clk, rst_n, out_valid, out_ready,
        {out_left_x, out_top_y, out_right_x, out_bottom_y,
         rect_count, rect_valid, overflow_flag})

    `DRRM_ASSERT(a_one_in_flight, clk, rst_n, in_valid && in_ready |=> !in_ready)

    `DRRM_ASSERT(a_empty_result_zero, clk, rst_n,
        out_valid && !rect_valid |-> out_left_x == 0 && out_top_y == 0 &&
        out_right_x == 0 && out_bottom_y == 0)

    `DRRM_ASSERT(a_count_bound, clk, rst_n, out_valid |-> rect_count <= CNT_W'(MAX_RECTS))

    `DRRM_ASSERT(a_overflow_sticky, clk, rst_n, !$fell(overflow_flag))

endmodule

bind dirty_rect_region_merge_unit drrm_checker #(
    .MAX_RECTS  (MAX_RECTS),
    .COORD_BITS (COORD_BITS)
) u_drrm_checker (.*);

`default_nettype wire
